// ===== src/hss_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hss_pkg
// Shared sizes, status codes and request structures of the hashed seen set.
// ============================================================================
package hss_pkg;

    // Bucket geometry. Both are powers of two, so that the bucket index is the
    // low hash bits and a store address is the bucket index above the slot.
    localparam int BUCKET_COUNT = 64;
    localparam int BUCKET_DEPTH = 64;

    localparam int HASH_W = 32;
    localparam int BKT_W  = $clog2(BUCKET_COUNT);
    localparam int IDX_W  = $clog2(BUCKET_DEPTH);
    localparam int FILL_W = $clog2(BUCKET_DEPTH + 1);
    localparam int ADDR_W = BKT_W + IDX_W;
    localparam int STAT_W = 2;

    typedef enum logic [STAT_W-1:0] {
        STATUS_DUP  = 2'd0,
        STATUS_NEW  = 2'd1,
        STATUS_FULL = 2'd2
    } t_status;

    // Request to the hash store: one read port and one write port.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [HASH_W-1:0] wr_data;
    } t_store_req;

    // Request to the fill count table.
    typedef struct packed {
        logic              rd_en;
        logic [BKT_W-1:0]  rd_bucket;
        logic              wr_en;
        logic [BKT_W-1:0]  wr_bucket;
        logic [FILL_W-1:0] wr_data;
    } t_fill_req;

endpackage

// ===== src/hashed_seen_set_insert.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hashed_seen_set_insert
// Remembers which 32-bit hashes have been seen, in per-bucket sorted lists,
// and reports each request as duplicate, new and stored, or new but full.
// ============================================================================
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ---------------------------
//  in       input      i_in_valid / o_in_stall    i_hash_value [31:0]
//  out      output     o_out_valid / i_out_stall  o_status [1:0]
//
//  One request is processed at a time. A request is accepted and its bucket
//  fill fetched, then a binary search runs (up to 7 steps for a bucket of 64,
//  each a store read and a compare), then a decision and the posting of the
//  status. An insert shifts the entries at and above the insert position up
//  by one slot, then writes the hash; the shift is the bound: one entry moves
//  per cycle over the store's read and write port.
//  The worst case is an insert at the front of a bucket holding 63 entries;
//  a duplicate or a refusal by a full bucket needs no shift.
//  Reset is synchronous and empties every bucket at once; the block is
//  ready for a request as soon as reset ends. The status sits in an output
//  register, so a stalled result does not keep the next request from entering.
//
module hashed_seen_set_insert (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [hss_pkg::HASH_W-1:0] i_hash_value,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output logic [hss_pkg::STAT_W-1:0] o_status,
    input  logic                       i_out_stall
);

    hss_pkg::t_store_req        store_req;
    hss_pkg::t_fill_req         fill_req;
    logic [hss_pkg::HASH_W-1:0] store_rdata;
    logic [hss_pkg::FILL_W-1:0] fill_rdata;

    // The sequencer drives both memories; each memory has a registered read port.
    hss_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_hash_value  (i_hash_value),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_status      (o_status),
        .i_out_stall   (i_out_stall),
        .o_store_req   (store_req),
        .i_store_rdata (store_rdata),
        .o_fill_req    (fill_req),
        .i_fill_rdata  (fill_rdata)
    );

    // Sorted entries of all buckets, bucket index in the upper address bits.
    hss_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (store_rdata)
    );

    // Entry count of each bucket.
    hss_fill u_fill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (fill_req),
        .o_rd_data (fill_rdata)
    );

endmodule

// ===== src/hss_store.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hss_store
// Hash store: one synchronous memory with a write port and a registered read
// port, holding the sorted entries of every bucket.
// ============================================================================
module hss_store (
    input  logic                       i_clk,
    input  hss_pkg::t_store_req        i_req,
    output logic [hss_pkg::HASH_W-1:0] o_rd_data
);

    localparam int Words = hss_pkg::BUCKET_COUNT * hss_pkg::BUCKET_DEPTH;

    logic [hss_pkg::HASH_W-1:0] r_mem [Words];
    logic [hss_pkg::HASH_W-1:0] r_rd_data;

    // Contents need no reset: only slots below a bucket's fill are ever read.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/hss_fill.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hss_fill
// Fill count table: one count per bucket in a small synchronous memory, with
// a valid bit per bucket so that reset empties every bucket at once.
// ============================================================================
module hss_fill (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hss_pkg::t_fill_req         i_req,
    output logic [hss_pkg::FILL_W-1:0] o_rd_data
);

    logic [hss_pkg::FILL_W-1:0]       r_mem [hss_pkg::BUCKET_COUNT];
    logic [hss_pkg::BUCKET_COUNT-1:0] r_vld;
    logic [hss_pkg::FILL_W-1:0]       r_rd_data;
    logic                             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_bucket] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_bucket];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_bucket] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_bucket];
            end
        end
    end

    // A bucket never written since reset reads as empty.
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== src/hss_ctrl.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hss_ctrl
// Sequencer: fetches the bucket fill, runs a lower-bound search over the
// store, shifts upper entries up to insert a new hash if room, posts status.
// ============================================================================
module hss_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [hss_pkg::HASH_W-1:0] i_hash_value,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output logic [hss_pkg::STAT_W-1:0] o_status,
    input  logic                       i_out_stall,
    output hss_pkg::t_store_req        o_store_req,
    input  logic [hss_pkg::HASH_W-1:0] i_store_rdata,
    output hss_pkg::t_fill_req         o_fill_req,
    input  logic [hss_pkg::FILL_W-1:0] i_fill_rdata
);

    localparam int FillW = hss_pkg::FILL_W;
    localparam int IdxW  = hss_pkg::IDX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_SRCH,
        S_CMP,
        S_SHIFT,
        S_RESULT
    } t_state;

    t_state                     r_state, n_state;
    logic [hss_pkg::HASH_W-1:0] r_key, n_key;
    logic [hss_pkg::BKT_W-1:0]  r_bucket, n_bucket;
    logic [FillW-1:0]           r_fill, n_fill;
    logic [FillW-1:0]           r_lo, n_lo;
    logic [FillW-1:0]           r_hi, n_hi;
    logic [IdxW-1:0]            r_mid, n_mid;
    logic                       r_hit, n_hit;
    logic [FillW-1:0]           r_cnt, n_cnt;
    logic [IdxW-1:0]            r_ridx, n_ridx;
    logic [IdxW-1:0]            r_widx, n_widx;
    logic                       r_wv, n_wv;
    hss_pkg::t_status           r_status, n_status;
    logic                       r_out_valid, n_out_valid;
    logic [hss_pkg::STAT_W-1:0] r_out_status, n_out_status;

    logic                       accept;
    logic                       out_free;
    logic [FillW:0]             mid_sum;

    assign accept   = (r_state == S_IDLE) && i_in_valid;
    assign out_free = !r_out_valid || !i_out_stall;
    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi};

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_bucket     = r_bucket;
        n_fill       = r_fill;
        n_lo         = r_lo;
        n_hi         = r_hi;
        n_mid        = r_mid;
        n_hit        = r_hit;
        n_cnt        = r_cnt;
        n_ridx       = r_ridx;
        n_widx       = r_widx;
        n_wv         = r_wv;
        n_status     = r_status;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        o_store_req  = '0;
        o_fill_req   = '0;

        unique case (r_state)
            S_IDLE: begin
                o_fill_req.rd_en     = 1'b1;
                o_fill_req.rd_bucket = i_hash_value[hss_pkg::BKT_W-1:0];
                if (accept) begin
                    n_key    = i_hash_value;
                    n_bucket = i_hash_value[hss_pkg::BKT_W-1:0];
                    n_state  = S_FILL;
                end
            end
            S_FILL: begin
                n_fill  = i_fill_rdata;
                n_lo    = '0;
                n_hi    = i_fill_rdata;
                n_hit   = 1'b0;
                n_state = S_SRCH;
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_mid               = IdxW'(mid_sum >> 1);
                    o_store_req.rd_en   = 1'b1;
                    o_store_req.rd_addr = {r_bucket, IdxW'(mid_sum >> 1)};
                    n_state             = S_CMP;
                end else if (r_hit) begin
                    n_status = hss_pkg::STATUS_DUP;
                    n_state  = S_RESULT;
                end else if (r_fill >= FillW'(hss_pkg::BUCKET_DEPTH)) begin
                    n_status = hss_pkg::STATUS_FULL;
                    n_state  = S_RESULT;
                end else begin
                    n_cnt   = r_fill - r_lo;
                    n_ridx  = IdxW'(r_fill - FillW'(1));
                    n_wv    = 1'b0;
                    n_state = S_SHIFT;
                end
            end
            S_CMP: begin
                if (i_store_rdata < r_key) begin
                    n_lo = FillW'(r_mid) + FillW'(1);
                end else begin
                    n_hi  = FillW'(r_mid);
                    n_hit = (i_store_rdata == r_key);
                end
                n_state = S_SRCH;
            end
            S_SHIFT: begin
                // Read slot j-1 while the slot read last cycle lands one higher.
                if (r_wv) begin
                    o_store_req.wr_en   = 1'b1;
                    o_store_req.wr_addr = {r_bucket, r_widx};
                    o_store_req.wr_data = i_store_rdata;
                end
                if (r_cnt != '0) begin
                    o_store_req.rd_en   = 1'b1;
                    o_store_req.rd_addr = {r_bucket, r_ridx};
                    n_wv                = 1'b1;
                    n_widx              = r_ridx + IdxW'(1);
                    n_ridx              = r_ridx - IdxW'(1);
                    n_cnt               = r_cnt - FillW'(1);
                end else begin
                    n_wv = 1'b0;
                    if (!r_wv) begin
                        o_store_req.wr_en    = 1'b1;
                        o_store_req.wr_addr  = {r_bucket, IdxW'(r_lo)};
                        o_store_req.wr_data  = r_key;
                        o_fill_req.wr_en     = 1'b1;
                        o_fill_req.wr_bucket = r_bucket;
                        o_fill_req.wr_data   = r_fill + FillW'(1);
                        n_status             = hss_pkg::STATUS_NEW;
                        n_state              = S_RESULT;
                    end
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_wv        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_wv        <= n_wv;
        end
        r_key        <= n_key;
        r_bucket     <= n_bucket;
        r_fill       <= n_fill;
        r_lo         <= n_lo;
        r_hi         <= n_hi;
        r_mid        <= n_mid;
        r_hit        <= n_hit;
        r_cnt        <= n_cnt;
        r_ridx       <= n_ridx;
        r_widx       <= n_widx;
        r_status     <= n_status;
        r_out_status <= n_out_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;

endmodule

// ===== src/hss_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// hss_checker
// Port-level checks of the hashed seen set, bound to its top level.
// ============================================================================
module hss_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic [hss_pkg::STAT_W-1:0] o_status,
    input logic                       i_out_stall
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status))
        else $error("stalled result changed");

    // Only the three defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == hss_pkg::STATUS_DUP) ||
                        (o_status == hss_pkg::STATUS_NEW) ||
                        (o_status == hss_pkg::STATUS_FULL))
        else $error("undefined status code");

    // The block works on one request at a time: it stalls right after taking one.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while busy");

    // A result appears no sooner than fill fetch and decision allow.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall) |=> !o_out_valid)
        else $error("result posted in the cycle after a request");

    // Reset leaves the block ready and with no result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

endmodule

bind hashed_seen_set_insert hss_checker u_hss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .o_status     (o_status),
    .i_out_stall  (i_out_stall)
);

// ===== sim/tb_hashed_seen_set_insert.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_hashed_seen_set_insert
// Self-checking bench for the hashed seen set. A scoreboard keeps its own
// copy of the bucketed sorted lists and predicts the status of each request.
// A short directed sequence comes first, then random requests aimed at two
// hot buckets so that buckets fill up, with replays of earlier hashes.
// ============================================================================
module tb_hashed_seen_set_insert;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic [hss_pkg::HASH_W-1:0] i_hash_value;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [hss_pkg::STAT_W-1:0] o_status;
    logic                       i_out_stall;

    // One status that the scoreboard still waits for, with the hash that
    // caused it so that a mismatch can name the request.
    typedef struct {
        logic [hss_pkg::HASH_W-1:0] hash;
        hss_pkg::t_status           status;
    } t_awaited;

    // Scoreboard: mirrors the per-bucket sorted lists and the fill counts,
    // and checks the returned status values in order.
    class seen_set_scoreboard;
        logic [hss_pkg::HASH_W-1:0] slots [hss_pkg::BUCKET_COUNT][hss_pkg::BUCKET_DEPTH];
        int unsigned                fill  [hss_pkg::BUCKET_COUNT];
        t_awaited                   awaited_status [$];
        int unsigned                mismatches;
        int unsigned                stored_count;
        int unsigned                dup_count;
        int unsigned                full_count;

        function new();
            foreach (fill[b]) begin
                fill[b] = 0;
            end
            mismatches   = 0;
            stored_count = 0;
            dup_count    = 0;
            full_count   = 0;
        endfunction

        // Predicts the status of an accepted request and updates the mirror.
        // The position is the first slot whose entry is not below the hash.
        function void note_request(logic [hss_pkg::HASH_W-1:0] h);
            int unsigned b;
            int unsigned pos;
            t_awaited    item;
            b   = h % hss_pkg::BUCKET_COUNT;
            pos = 0;
            while (pos < fill[b] && slots[b][pos] < h) begin
                pos++;
            end
            item.hash = h;
            if (pos < fill[b] && slots[b][pos] == h) begin
                item.status = hss_pkg::STATUS_DUP;
                dup_count++;
            end else if (fill[b] >= hss_pkg::BUCKET_DEPTH) begin
                // A full bucket refuses an unseen hash and stays unchanged.
                item.status = hss_pkg::STATUS_FULL;
                full_count++;
            end else begin
                for (int k = fill[b]; k > pos; k--) begin
                    slots[b][k] = slots[b][k-1];
                end
                slots[b][pos] = h;
                fill[b]++;
                item.status = hss_pkg::STATUS_NEW;
                stored_count++;
            end
            awaited_status.push_back(item);
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns: MISMATCH %s", $time, msg);
            mismatches++;
        endtask

        task check_status(logic [hss_pkg::STAT_W-1:0] got);
            t_awaited item;
            if (awaited_status.size() == 0) begin
                report_mismatch($sformatf("status %0d with no request pending", got));
            end else begin
                item = awaited_status.pop_front();
                if (got !== item.status) begin
                    report_mismatch($sformatf("hash %08h: status %0d, predicted %0d",
                                              item.hash, got, item.status));
                end
            end
        endtask
    endclass

    seen_set_scoreboard sb;

    // Pressure knobs. The odds give one chance in (odds + 1) per request or
    // per cycle to start an idle burst; zero turns idling off. Once settled
    // is set, neither side idles any more.
    int unsigned                gap_odds;
    int unsigned                stall_odds;
    bit                         settled;
    int unsigned                hot_a;
    int unsigned                hot_b;
    logic [hss_pkg::HASH_W-1:0] sent_hashes [$];
    logic [hss_pkg::HASH_W-1:0] directed_hashes [$];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    hashed_seen_set_insert uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_hash_value (i_hash_value),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .i_out_stall  (i_out_stall)
    );

    // Holds the request channel idle for a number of cycles, with junk on the
    // data lines to show that the block ignores them while valid is low.
    task automatic idle_cycles(input int unsigned n);
        i_in_valid   <= 1'b0;
        i_hash_value <= $urandom();
        repeat (n) @(posedge i_clk);
    endtask

    // Presents one request and returns at the edge where it is accepted. The
    // values sampled right after the edge are the ones the block saw there.
    task automatic send_hash(input logic [hss_pkg::HASH_W-1:0] h);
        i_in_valid   <= 1'b1;
        i_hash_value <= h;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sb.note_request(h);
    endtask

    // Random hash: about a third are replays of earlier hashes, about a third
    // land in one of two hot buckets (which therefore fill up and start to
    // refuse new hashes), and the rest are uniform over all 32 bits.
    function automatic logic [hss_pkg::HASH_W-1:0] pick_hash();
        int unsigned                r;
        logic [hss_pkg::HASH_W-1:0] h;
        r = $urandom_range(0, 99);
        if (r < 30 && sent_hashes.size() != 0) begin
            h = sent_hashes[$urandom_range(0, sent_hashes.size() - 1)];
        end else if (r < 66) begin
            h = $urandom();
            if (r < 33) begin
                h[hss_pkg::HASH_W-1:hss_pkg::BKT_W] = '1;
            end else if (r < 36) begin
                h[hss_pkg::HASH_W-1:hss_pkg::BKT_W] = '0;
            end
            h[hss_pkg::BKT_W-1:0] = (r % 2 != 0) ? hot_a[hss_pkg::BKT_W-1:0]
                                                 : hot_b[hss_pkg::BKT_W-1:0];
        end else begin
            h = $urandom();
        end
        sent_hashes.push_back(h);
        return h;
    endfunction

    // Result side: stalls in random bursts while the current pressure level
    // allows it, and never once the run has settled.
    initial begin : out_stall_driver
        int unsigned burst;
        burst = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (settled) begin
                burst = 0;
            end else if (burst == 0 && stall_odds != 0
                         && $urandom_range(0, stall_odds) == 0) begin
                burst = $urandom_range(1, 18);
            end
            if (burst != 0) begin
                i_out_stall <= 1'b1;
                burst--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Every status taken by the bench is checked against the oldest
    // prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_status(o_status);
        end
    end

    initial begin : main_sequence
        int unsigned n;
        sb           = new();
        gap_odds     = 0;
        stall_odds   = 0;
        settled      = 1'b0;
        hot_a        = $urandom_range(0, hss_pkg::BUCKET_COUNT - 1);
        hot_b        = (hot_a + 1 + $urandom_range(0, hss_pkg::BUCKET_COUNT - 2))
                       % hss_pkg::BUCKET_COUNT;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_hash_value <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: the extreme hashes and their repeats, the two
        // alternating bit patterns, then one bucket filled out of order so
        // that inserts land at the front, in the middle and at the end, with
        // a few repeats of entries that have been shifted.
        directed_hashes = '{
            32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
            32'hAAAA_AAAA, 32'h5555_5555,
            32'h0000_0A05, 32'h0000_0805, 32'h0000_0605, 32'h0000_0405,
            32'h0000_0205, 32'h0000_0505, 32'h0000_0905, 32'h0000_0105,
            32'h0000_0B05, 32'h0000_0505, 32'h0000_0105, 32'h0000_0B05,
            32'hFFFF_FFC5, 32'h0000_0005
        };
        foreach (directed_hashes[k]) begin
            sent_hashes.push_back(directed_hashes[k]);
            send_hash(directed_hashes[k]);
        end

        // Random part. The pressure level changes every hundred requests,
        // and the last stretch runs with both sides always ready.
        for (n = 0; n < 800; n++) begin
            if (n % 100 == 0) begin
                if (n >= 700) begin
                    settled    = 1'b1;
                    gap_odds   = 0;
                    stall_odds = 0;
                end else begin
                    gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            if (gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
                idle_cycles($urandom_range(1, 18));
            end
            send_hash(pick_hash());
        end
        i_in_valid <= 1'b0;

        // Drain: wait for every predicted status, then watch a while longer
        // so that a stray extra status would still be caught.
        while (sb.awaited_status.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);

        $display("Covered %0d requests: %0d stored, %0d duplicates, %0d refused by full buckets.",
                 sb.stored_count + sb.dup_count + sb.full_count,
                 sb.stored_count, sb.dup_count, sb.full_count);
        $display("Hot buckets %0d and %0d; %0d mismatches.", hot_a, hot_b, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_hashed_seen_set_insert passed");
        end else begin
            $display("tb_hashed_seen_set_insert failed");
        end
        $finish;
    end

    // This bound is several times what a correct run needs, even under the
    // heaviest idling.
    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d statuses outstanding.", sb.awaited_status.size());
        $display("tb_hashed_seen_set_insert failed");
        $finish;
    end

endmodule

// ===== files.f =====
src/hss_pkg.sv
src/hss_store.sv
src/hss_fill.sv
src/hss_ctrl.sv
src/hashed_seen_set_insert.sv
src/hss_checker.sv
sim/tb_hashed_seen_set_insert.sv
